[rtl/csv_decimal_field_parser_core_defines.svh]
// -----------------------------------------------------------------------------
// csv decimal field parser assertion macros
// shared property forms, used with the clk and arst_n of the enclosing module
// -----------------------------------------------------------------------------
`ifndef CSV_DECIMAL_FIELD_PARSER_CORE_DEFINES_SVH
`define CSV_DECIMAL_FIELD_PARSER_CORE_DEFINES_SVH

// invariant that holds at every edge out of reset
`define CSVP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence in the cycle after the trigger
`define CSVP_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

[rtl/csvp_pkg.sv]
// -----------------------------------------------------------------------------
// csvp_pkg
// types and constants shared by the csv decimal field parser modules
// -----------------------------------------------------------------------------
package csvp_pkg;

	// character codes
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// field widths
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 6;
	localparam int VALUE_W   = 60;
	localparam int INT_W     = 54;
	localparam int FRAC_W    = 7;
	localparam int FDIG_W    = 2;
	localparam int FRAC_KEEP = 2;
	localparam int TDATA_W   = 72;

	// item held in the input register
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] ch_byte;
		logic              eor;
	} in_item_t;

	// result handed to the output register
	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] field_index;
		logic [VALUE_W-1:0] value;
		logic               format_error;
	} result_t;

endpackage

[rtl/csv_decimal_field_parser_core.sv]
// -----------------------------------------------------------------------------
// csv_decimal_field_parser_core: comma-separated decimal field parser
// one character per cycle; input and result registers lie before m_tvalid
// a held result stalls only a field-closing comma, and only while m_tready is low
// arst_n clears the field state, comma count and both valid flags at once
// -----------------------------------------------------------------------------
module csv_decimal_field_parser_core #(
	parameter int MAX_FIELD_CHARS = 16,
	parameter int MAX_FIELDS      = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [csvp_pkg::CHAR_W-1:0]  s_tdata,  // char_byte
	input  logic                         s_tlast,  // end_of_record
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csvp_pkg::TDATA_W-1:0] m_tdata,  // field_index, value, zero pad
	output logic [0:0]                   m_tuser   // format_error
);

	csvp_pkg::in_item_t item_s1;
	csvp_pkg::result_t  res;
	logic               adv;
	logic               out_free;

	// input register
	csvp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.adv      (adv),
		.item_s1  (item_s1)
	);

	// field parsing
	csvp_field_core #(
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS),
		.MAX_FIELDS      (MAX_FIELDS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.out_free (out_free),
		.adv      (adv),
		.res      (res)
	);

	// result register
	csvp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[rtl/csvp_in_stage.sv]
// -----------------------------------------------------------------------------
// csvp_in_stage
// input register; refills in the same cycle that its item is consumed
// -----------------------------------------------------------------------------
module csvp_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [csvp_pkg::CHAR_W-1:0] s_tdata,  // char_byte
	input  logic                       s_tlast,  // end_of_record
	input  logic                       adv,
	output csvp_pkg::in_item_t          item_s1
);

	logic                        valid_s1;
	logic [csvp_pkg::CHAR_W-1:0] ch_s1;
	logic                        eor_s1;

	// room when empty or when the held item moves on
	assign s_tready = !valid_s1 || adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eor_s1 <= s_tlast;
		end
	end

	assign item_s1.valid   = valid_s1;
	assign item_s1.ch_byte = ch_s1;
	assign item_s1.eor     = eor_s1;

endmodule

[rtl/csvp_field_core.sv]
// -----------------------------------------------------------------------------
// csvp_field_core
// field state, per-character accumulation and result formation
// -----------------------------------------------------------------------------
`include "csv_decimal_field_parser_core_defines.svh"

module csvp_field_core #(
	parameter int MAX_FIELD_CHARS = 16,
	parameter int MAX_FIELDS      = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csvp_pkg::in_item_t item_s1,
	input  logic               out_free,
	output logic               adv,
	output csvp_pkg::result_t  res
);

	localparam int CCW = $clog2(MAX_FIELD_CHARS + 1);
	localparam int KW  = $clog2(MAX_FIELDS + 1);

	logic [KW-1:0]                 comma_count_q, comma_count_d;
	logic [csvp_pkg::INT_W-1:0]    int_q, int_d;
	logic [csvp_pkg::FRAC_W-1:0]   frac_q, frac_d;
	logic [csvp_pkg::FDIG_W-1:0]   fdig_q, fdig_d;
	logic [CCW-1:0]                char_count_q, char_count_d;
	logic                          dot_q, dot_d;
	logic                          bad_q, bad_d;

	logic                          is_comma;
	logic                          is_dot;
	logic                          is_digit;
	logic [3:0]                    digit;
	logic                          ends_field;
	logic [csvp_pkg::FRAC_W-1:0]   frac_scaled;
	logic                          err;
	logic [KW-1:0]                 idx;

	// character decode
	assign is_comma = item_s1.ch_byte == csvp_pkg::CHAR_COMMA;
	assign is_dot   = item_s1.ch_byte == csvp_pkg::CHAR_DOT;
	assign is_digit = (item_s1.ch_byte >= csvp_pkg::CHAR_ZERO)
		&& (item_s1.ch_byte <= csvp_pkg::CHAR_NINE);
	assign digit    = 4'(item_s1.ch_byte - csvp_pkg::CHAR_ZERO);

	// a comma after the key closes a field and needs the output register
	assign ends_field = item_s1.valid && !item_s1.eor && is_comma
		&& (comma_count_q != '0);
	assign adv = item_s1.valid && (!ends_field || out_free);

	// result of the field being closed
	assign frac_scaled = (fdig_q == csvp_pkg::FDIG_W'(1))
		? csvp_pkg::FRAC_W'({frac_q, 3'b000} + {frac_q, 1'b0}) : frac_q;
	assign err = bad_q || (char_count_q == '0);
	assign idx = comma_count_q - KW'(1);

	always_comb begin
		res.valid        = adv && ends_field;
		res.field_index  = csvp_pkg::INDEX_W'(idx);
		res.format_error = err;
		res.value        = '0;
		if (!err) begin
			res.value = csvp_pkg::VALUE_W'({int_q, 6'b000000})
				+ csvp_pkg::VALUE_W'({int_q, 5'b00000})
				+ csvp_pkg::VALUE_W'({int_q, 2'b00})
				+ csvp_pkg::VALUE_W'(frac_scaled);
		end
	end

	// next field state
	always_comb begin
		comma_count_d = comma_count_q;
		int_d         = int_q;
		frac_d        = frac_q;
		fdig_d        = fdig_q;
		char_count_d  = char_count_q;
		dot_d         = dot_q;
		bad_d         = bad_q;
		if (item_s1.eor || is_comma) begin
			// record end or field end: clear the field
			int_d        = '0;
			frac_d       = '0;
			fdig_d       = '0;
			char_count_d = '0;
			dot_d        = 1'b0;
			bad_d        = 1'b0;
			if (item_s1.eor) begin
				comma_count_d = '0;
			end else if (comma_count_q < KW'(MAX_FIELDS)) begin
				comma_count_d = comma_count_q + KW'(1);
			end
		end else if (comma_count_q != '0) begin
			if (char_count_q >= CCW'(MAX_FIELD_CHARS)) begin
				bad_d = 1'b1;
			end else begin
				char_count_d = char_count_q + CCW'(1);
				if (is_digit) begin
					if (!dot_q) begin
						int_d = {int_q[csvp_pkg::INT_W-4:0], 3'b000}
							+ {int_q[csvp_pkg::INT_W-2:0], 1'b0}
							+ csvp_pkg::INT_W'(digit);
					end else if (fdig_q < csvp_pkg::FDIG_W'(csvp_pkg::FRAC_KEEP)) begin
						frac_d = {frac_q[csvp_pkg::FRAC_W-4:0], 3'b000}
							+ {frac_q[csvp_pkg::FRAC_W-2:0], 1'b0}
							+ csvp_pkg::FRAC_W'(digit);
						fdig_d = fdig_q + csvp_pkg::FDIG_W'(1);
					end
				end else if (is_dot) begin
					if (dot_q) begin
						bad_d = 1'b1;
					end else begin
						dot_d = 1'b1;
					end
				end else begin
					bad_d = 1'b1;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_count_q <= '0;
			int_q         <= '0;
			frac_q        <= '0;
			fdig_q        <= '0;
			char_count_q  <= '0;
			dot_q         <= 1'b0;
			bad_q         <= 1'b0;
		end else if (adv) begin
			comma_count_q <= comma_count_d;
			int_q         <= int_d;
			frac_q        <= frac_d;
			fdig_q        <= fdig_d;
			char_count_q  <= char_count_d;
			dot_q         <= dot_d;
			bad_q         <= bad_d;
		end
	end

	// checks
	`CSVP_ASSERT_ALWAYS(a_comma_range, comma_count_q <= KW'(MAX_FIELDS), "comma count overrun")
	`CSVP_ASSERT_ALWAYS(a_char_range, char_count_q <= CCW'(MAX_FIELD_CHARS), "char count overrun")
	`CSVP_ASSERT_ALWAYS(a_frac_range, (fdig_q <= 2'd2) && (frac_q < 7'd100), "fraction overrun")
	`CSVP_ASSERT_NEXT(a_eor_clear, adv && item_s1.eor, (comma_count_q == '0) && (char_count_q == '0) && !bad_q, "record end did not clear")

endmodule

[rtl/csvp_out_stage.sv]
// -----------------------------------------------------------------------------
// csvp_out_stage
// result register on the master side
// -----------------------------------------------------------------------------
module csvp_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csvp_pkg::result_t            res,
	output logic                         out_free,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csvp_pkg::TDATA_W-1:0] m_tdata,  // field_index, value, zero pad
	output logic [0:0]                   m_tuser   // format_error
);

	logic                          valid_q;
	logic [csvp_pkg::INDEX_W-1:0]  index_q;
	logic [csvp_pkg::VALUE_W-1:0]  value_q;
	logic                          err_q;

	assign out_free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			index_q <= res.field_index;
			value_q <= res.value;
			err_q   <= res.format_error;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(csvp_pkg::TDATA_W - csvp_pkg::VALUE_W - csvp_pkg::INDEX_W){1'b0}},
		value_q, index_q};
	assign m_tuser  = err_q;

endmodule

[verif/csv_decimal_field_parser_checker.sv]
// -----------------------------------------------------------------------------
// csv decimal field parser checker
// watches both stream channels, predicts each field result from the accepted
// characters and compares every accepted result against the oldest prediction
// -----------------------------------------------------------------------------
module csv_decimal_field_parser_checker #(
	parameter int MAX_FIELD_CHARS = 16,
	parameter int MAX_FIELDS      = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [csvp_pkg::CHAR_W-1:0]  s_tdata,  // char_byte
	input  logic                         s_tlast,  // end_of_record
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [csvp_pkg::TDATA_W-1:0] m_tdata,  // field_index, value, zero pad
	input  logic [0:0]                   m_tuser,  // format_error
	output int                           mismatch_count,
	output int                           results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [csvp_pkg::INDEX_W-1:0] field_index;
		logic [csvp_pkg::VALUE_W-1:0] value;
		logic                         format_error;
	} field_result_t;

	field_result_t expected_fields[$];

	// parser state as seen by the prediction
	logic [6:0]                  comma_cnt;
	logic [csvp_pkg::INT_W-1:0]  int_acc;
	logic [csvp_pkg::FRAC_W-1:0] frac_acc;
	logic [4:0]                  frac_digits;
	logic [4:0]                  char_cnt;
	logic                        dot_seen;
	logic                        bad_field;

	task automatic clear_field();
		int_acc     = '0;
		frac_acc    = '0;
		frac_digits = '0;
		char_cnt    = '0;
		dot_seen    = 1'b0;
		bad_field   = 1'b0;
	endtask

	// advance the field state by one character, queue a result on a field comma
	task automatic parse_char(input logic [csvp_pkg::CHAR_W-1:0] ch, input logic eor);
		field_result_t res;
		logic [63:0]   wide_value;
		logic [3:0]    digit;
		if (eor) begin
			comma_cnt = '0;
			clear_field();
		end else if (ch == csvp_pkg::CHAR_COMMA && comma_cnt == 0) begin
			// comma closing the key
			comma_cnt = 7'd1;
			clear_field();
		end else if (ch == csvp_pkg::CHAR_COMMA) begin
			res.field_index  = (comma_cnt > 7'(MAX_FIELDS))
				? csvp_pkg::INDEX_W'(MAX_FIELDS - 1)
				: csvp_pkg::INDEX_W'(comma_cnt - 7'd1);
			res.format_error = bad_field || (char_cnt == 0);
			// a single fraction digit counts as tenths
			wide_value = 64'(int_acc) * 64'd100
				+ ((frac_digits == 1) ? 64'(frac_acc) * 64'd10 : 64'(frac_acc));
			res.value = res.format_error ? '0 : wide_value[csvp_pkg::VALUE_W-1:0];
			expected_fields.push_back(res);
			if (comma_cnt < 7'(MAX_FIELDS))
				comma_cnt++;
			clear_field();
		end else if (comma_cnt != 0) begin
			if (char_cnt >= 5'(MAX_FIELD_CHARS)) begin
				// over length, flag and drop the character
				bad_field = 1'b1;
			end else begin
				char_cnt++;
				if (ch >= csvp_pkg::CHAR_ZERO && ch <= csvp_pkg::CHAR_NINE) begin
					digit = 4'(ch - csvp_pkg::CHAR_ZERO);
					if (!dot_seen) begin
						int_acc = csvp_pkg::INT_W'(64'(int_acc) * 64'd10 + 64'(digit));
					end else if (frac_digits < csvp_pkg::FRAC_KEEP) begin
						frac_acc = csvp_pkg::FRAC_W'(32'(frac_acc) * 10 + 32'(digit));
						frac_digits++;
					end
				end else if (ch == csvp_pkg::CHAR_DOT) begin
					if (dot_seen)
						bad_field = 1'b1;
					else
						dot_seen = 1'b1;
				end else begin
					bad_field = 1'b1;
				end
			end
		end
	endtask

	// compare results first, then predict from the accepted character
	always @(posedge clk or negedge arst_n) begin
		field_result_t                want;
		logic [csvp_pkg::INDEX_W-1:0] got_index;
		logic [csvp_pkg::VALUE_W-1:0] got_value;
		logic                         got_error;
		int                           fails;
		if (!arst_n) begin
			expected_fields.delete();
			comma_cnt = '0;
			clear_field();
			mismatch_count  <= 0;
			results_pending <= 0;
		end else begin
			fails = 0;
			if (m_tvalid && m_tready) begin
				got_index = m_tdata[csvp_pkg::INDEX_W-1:0];
				got_value = m_tdata[csvp_pkg::INDEX_W+csvp_pkg::VALUE_W-1:csvp_pkg::INDEX_W];
				got_error = m_tuser[0];
				if (expected_fields.size() == 0) begin
					$display("%0t: unexpected result: index %0d value %0d error %0b",
						$time, got_index, got_value, got_error);
					fails++;
				end else begin
					want = expected_fields.pop_front();
					if (got_index !== want.field_index) begin
						$display("%0t: field_index mismatch: expected %0d, actual %0d",
							$time, want.field_index, got_index);
						fails++;
					end
					if (got_value !== want.value) begin
						$display("%0t: value mismatch (index %0d): expected %0d, actual %0d",
							$time, want.field_index, want.value, got_value);
						fails++;
					end
					if (got_error !== want.format_error) begin
						$display("%0t: format_error mismatch (index %0d): expected %0b, actual %0b",
							$time, want.field_index, want.format_error, got_error);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready)
				parse_char(s_tdata, s_tlast);
			mismatch_count  <= mismatch_count + fails;
			results_pending <= expected_fields.size();
		end
	end

endmodule

[verif/tb.sv]
// -----------------------------------------------------------------------------
// csv decimal field parser testbench
// streams directed and random quote records through the parser under varying
// backpressure and source gaps; a checker module scores every field result
// -----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_CHARS = 16;
	localparam int FIELD_LIMIT = 64;
	localparam int RANDOM_ITEMS = 550;
	localparam int HOLDOFF_CYCLES = 300;

	typedef struct packed {
		logic [csvp_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} char_item_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [csvp_pkg::CHAR_W-1:0]  s_tdata  = '0;
	logic                         s_tlast  = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [csvp_pkg::TDATA_W-1:0] m_tdata;
	logic [0:0]                   m_tuser;
	int                           mismatch_count;
	int                           results_pending;

	char_item_t char_stream[$];
	int         traffic_phase = 0;

	csv_decimal_field_parser_core #(
		.MAX_FIELD_CHARS(FIELD_CHARS),
		.MAX_FIELDS(FIELD_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	csv_decimal_field_parser_checker #(
		.MAX_FIELD_CHARS(FIELD_CHARS),
		.MAX_FIELDS(FIELD_LIMIT)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatch_count(mismatch_count),
		.results_pending(results_pending)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic push_char(input logic [csvp_pkg::CHAR_W-1:0] ch, input logic last);
		char_item_t it;
		it.ch   = ch;
		it.last = last;
		char_stream.push_back(it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0);
	endtask

	task automatic push_digits(input int n, input bit nines);
		repeat (n)
			push_char(csvp_pkg::CHAR_ZERO + (nines ? 8'd9 : 8'($urandom_range(0, 9))), 1'b0);
	endtask

	// any byte except the field separator
	function automatic logic [csvp_pkg::CHAR_W-1:0] noise_byte();
		logic [csvp_pkg::CHAR_W-1:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == csvp_pkg::CHAR_COMMA);
		return b;
	endfunction

	// one field body, mostly well formed numbers
	task automatic push_random_field();
		int kind;
		int n_int;
		int n_frac;
		int spot;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5);
			push_digits(n_int, 1'b0);
			if ($urandom_range(0, 99) < 60) begin
				n_frac = $urandom_range(0, 3);
				push_char(csvp_pkg::CHAR_DOT, 1'b0);
				push_digits(n_frac, 1'b0);
			end
		end else if (kind < 62) begin
			// empty field
		end else if (kind < 70) begin
			// too long
			n_int = $urandom_range(17, 20);
			spot  = $urandom_range(0, n_int);
			push_digits(spot, 1'b0);
			if ($urandom_range(0, 1))
				push_char(csvp_pkg::CHAR_DOT, 1'b0);
			push_digits(n_int - spot, 1'b0);
		end else if (kind < 80) begin
			// exactly full length, largest value now and then
			if ($urandom_range(0, 2) == 0) begin
				push_digits(FIELD_CHARS, 1'b1);
			end else begin
				push_digits(13, 1'b0);
				push_char(csvp_pkg::CHAR_DOT, 1'b0);
				push_digits(2, 1'b0);
			end
		end else if (kind < 88) begin
			// stray character inside digits
			push_digits($urandom_range(0, 3), 1'b0);
			push_char(noise_byte(), 1'b0);
			push_digits($urandom_range(0, 3), 1'b0);
		end else if (kind < 94) begin
			// second dot
			push_digits($urandom_range(0, 2), 1'b0);
			push_char(csvp_pkg::CHAR_DOT, 1'b0);
			push_digits($urandom_range(0, 2), 1'b0);
			push_char(csvp_pkg::CHAR_DOT, 1'b0);
			push_digits($urandom_range(0, 2), 1'b0);
		end else begin
			repeat ($urandom_range(1, 4))
				push_char(noise_byte(), 1'b0);
		end
	endtask

	// key, fields, trailing text, then usually an end of record
	task automatic push_record(input int n_fields);
		int ending;
		repeat ($urandom_range(0, 3))
			push_char(noise_byte(), 1'b0);
		push_char(csvp_pkg::CHAR_COMMA, 1'b0);
		repeat (n_fields) begin
			push_random_field();
			push_char(csvp_pkg::CHAR_COMMA, 1'b0);
		end
		if ($urandom_range(0, 1))
			push_random_field();
		ending = $urandom_range(0, 9);
		if (ending == 1)
			push_char(csvp_pkg::CHAR_COMMA, 1'b1);
		else if (ending != 0)
			push_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// stimulus and verdict
	initial begin
		int n_items;
		int idle_pct;
		int base;
		// directed record: zero, tenths, dropped digits, lone and trailing dot,
		// empty field, double dot, bad byte, trailing text, eor on a comma
		push_text("K,0,1.5,12.345,.,7.,,1..2,");
		push_char(8'h00, 1'b0);
		push_char(csvp_pkg::CHAR_COMMA, 1'b0);
		push_text("9");
		push_char(csvp_pkg::CHAR_COMMA, 1'b1);
		push_char(8'hFF, 1'b1);
		base = char_stream.size();
		// field index saturation
		push_text("S,");
		repeat (FIELD_LIMIT + 6) begin
			push_digits(1, 1'b0);
			push_char(csvp_pkg::CHAR_COMMA, 1'b0);
		end
		push_char(8'($urandom_range(0, 255)), 1'b1);
		while (char_stream.size() < base + RANDOM_ITEMS)
			push_record($urandom_range(0, 8));
		n_items = char_stream.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < n_items; i++) begin
			traffic_phase = (i < n_items / 3) ? 0 : (i < 2 * n_items / 3) ? 1 : 2;
			// drain everything before the first switch of the idling pattern
			if (i == n_items / 3) begin
				s_tvalid <= 1'b0;
				do
					@(posedge clk);
				while (results_pending != 0);
			end
			idle_pct = (traffic_phase == 0) ? 20 : (traffic_phase == 1) ? 47 : 0;
			while ($urandom_range(0, 99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= char_stream[i].ch;
			s_tlast  <= char_stream[i].last;
			do
				@(posedge clk);
			while (!s_tready);
		end
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side backpressure, with one long hold-off once no source gaps remain
	initial begin
		int hold_left;
		bit hold_done;
		int stall_pct;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && traffic_phase == 2) begin
				hold_done = 1'b1;
				hold_left = HOLDOFF_CYCLES;
			end
			stall_pct = (traffic_phase == 0) ? 47 : (traffic_phase == 1) ? 20 : 0;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/csvp_pkg.sv
rtl/csvp_in_stage.sv
rtl/csvp_field_core.sv
rtl/csvp_out_stage.sv
rtl/csv_decimal_field_parser_core.sv
verif/csv_decimal_field_parser_checker.sv
verif/tb.sv
